// File: rtl/rbpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpe_pkg
// Types, codes and header helpers for the byte-run packet encoder.
// ----------------------------------------------------------------------------
package rbpe_pkg;

    typedef enum logic [1:0] {
        CM_IDLE,
        CM_HELD,
        CM_LIT,
        CM_RUN
    } coder_mode_t;

    typedef enum logic [2:0] {
        ES_READY,
        ES_LHDR,
        ES_LDATA,
        ES_SHDR,
        ES_SVAL
    } emit_state_t;

    localparam int          WORD_W         = 64;
    localparam int          OUT_W          = 72;
    localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;
    localparam logic [7:0]  RUN_FLAG       = 8'h80;
    localparam logic [2:0]  LANE_LAST      = 3'd7;

    // literal header: count-1 with bit 7 clear
    function automatic logic [7:0] lit_header(input logic [7:0] count);
        logic [7:0] m1;
        m1 = count - 8'd1;
        return {1'b0, m1[6:0] & HDR_COUNT_MASK};
    endfunction

    // run header: 0x80 | (count-1)
    function automatic logic [7:0] run_header(input logic [7:0] count);
        logic [7:0] m1;
        m1 = count - 8'd1;
        return RUN_FLAG | {1'b0, m1[6:0] & HDR_COUNT_MASK};
    endfunction

endpackage
`default_nettype wire

// File: rtl/rle_byte_packet_encoder.sv
`default_nettype none
// Timing: a byte is taken while the sequencer is ready; a byte that finishes no packet leaves the
// block ready again on the next cycle. A literal packet is then sent as its header and its bytes,
// and a run or single-byte packet as header and value, one packet byte a cycle through
// the word assembler and the store's single read port, unless a stall on m_tready holds it.
// No new byte is taken while the packets that a byte closed are still being sent.
// Reset: synchronous, active low; clears control state. The literal store is not cleared.
// ----------------------------------------------------------------------------
// rle_byte_packet_encoder
// Groups tile bytes into literal and run packets and sends them in 8-byte words.
// ----------------------------------------------------------------------------
module rle_byte_packet_encoder #(
    parameter int MAX_PACKET = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // tile_end
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [71:0] m_tdata,   // [63:0] word_bytes, [67:64] byte_count, [68] last_word
    output logic        m_tlast,   // packet_done
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int AW = $clog2(MAX_PACKET);
    localparam int CW = $clog2(MAX_PACKET + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PACKET);

    // coder state
    rbpe_pkg::coder_mode_t mode_reg, mode_next;
    logic [CW-1:0] lit_cnt_reg, lit_cnt_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [7:0]    run_val_reg, run_val_next;
    logic [7:0]    held_reg, held_next;
    logic [7:0]    last1_reg, last1_next;
    logic [7:0]    last2_reg, last2_next;

    // pending packets of the current item
    logic [CW-1:0] lit_len_reg, lit_len_next;
    logic [1:0]    sh_cnt_reg, sh_cnt_next;
    logic [7:0]    sh_hdr_reg [2];
    logic [7:0]    sh_val_reg [2];
    logic [7:0]    sh_hdr_next [2];
    logic [7:0]    sh_val_next [2];
    logic [CW-1:0] idx_reg, idx_next;

    // sequencer
    rbpe_pkg::emit_state_t es_reg, es_next;

    // literal store
    logic [7:0]    lit_mem [MAX_PACKET];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rd_data_reg;

    // job from the accepted byte
    logic          job_lit;
    logic [CW-1:0] job_len;
    logic [1:0]    job_sh_cnt;
    logic [7:0]    job_hdr [2];
    logic [7:0]    job_val [2];

    // word assembler and output register
    logic [63:0]   asm_word_reg, asm_word_next;
    logic [2:0]    asm_fill_reg, asm_fill_next;
    logic          m_valid_reg, m_valid_next;
    logic [63:0]   m_word_reg, m_word_next;
    logic [3:0]    m_count_reg, m_count_next;
    logic          m_pdone_reg, m_pdone_next;
    logic          m_last_reg, m_last_next;

    logic          acc;
    logic          push_valid;
    logic [7:0]    push_byte;
    logic          push_pend;
    logic          push_jend;
    logic          push_done;
    logic          complete;
    logic          out_free;
    logic          lit_last;
    logic [63:0]   word_w;

    assign s_tready = (es_reg == rbpe_pkg::ES_READY);
    assign acc      = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // coder: one byte a cycle while the sequencer is ready, decides which packets close
    // ------------------------------------------------------------------
    always_comb begin : proc_coder
        rbpe_pkg::coder_mode_t m;
        logic [CW-1:0] cnt;
        logic [CW-1:0] rl;
        logic [7:0]    rv;
        logic [7:0]    held;
        logic [7:0]    l1;
        logic [7:0]    l2;
        logic          b_sh_v;
        logic [7:0]    b_sh_h;
        logic [7:0]    b_sh_d;
        logic          e_sh_v;
        logic [7:0]    e_sh_h;
        logic [7:0]    e_sh_d;
        logic          triple;

        m       = mode_reg;
        cnt     = lit_cnt_reg;
        rl      = run_len_reg;
        rv      = run_val_reg;
        held    = held_reg;
        l1      = last1_reg;
        l2      = last2_reg;
        b_sh_v  = 1'b0;
        b_sh_h  = '0;
        b_sh_d  = '0;
        e_sh_v  = 1'b0;
        e_sh_h  = '0;
        e_sh_d  = '0;
        job_lit = 1'b0;
        job_len = lit_len_reg;
        mem_we    = 1'b0;
        mem_waddr = lit_cnt_reg[AW-1:0];
        mem_wdata = s_tdata;
        triple  = (lit_cnt_reg >= CW'(3)) && (last1_reg == s_tdata) &&
                  (last2_reg == s_tdata);

        case (mode_reg)
            rbpe_pkg::CM_IDLE: begin
                // held byte also goes to entry 0 for a literal that may follow
                held      = s_tdata;
                mem_we    = 1'b1;
                mem_waddr = AW'(0);
                m         = rbpe_pkg::CM_HELD;
            end
            rbpe_pkg::CM_HELD: begin
                if (s_tdata == held_reg) begin
                    rv = s_tdata;
                    rl = CW'(2);
                    m  = rbpe_pkg::CM_RUN;
                    if (rl >= MAX_CNT) begin
                        b_sh_v = 1'b1;
                        b_sh_h = rbpe_pkg::run_header(8'(rl));
                        b_sh_d = rv;
                        rl     = '0;
                        m      = rbpe_pkg::CM_IDLE;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(1);
                    cnt       = CW'(2);
                    l2        = held_reg;
                    l1        = s_tdata;
                    m         = rbpe_pkg::CM_LIT;
                    if (cnt >= MAX_CNT) begin
                        job_lit = 1'b1;
                        job_len = cnt;
                        cnt     = '0;
                        m       = rbpe_pkg::CM_IDLE;
                    end
                end
            end
            rbpe_pkg::CM_LIT: begin
                if (triple) begin
                    // drop the last two bytes from the literal, they open the run
                    job_lit = 1'b1;
                    job_len = lit_cnt_reg - CW'(2);
                    cnt     = '0;
                    rv      = s_tdata;
                    rl      = CW'(3);
                    m       = rbpe_pkg::CM_RUN;
                    if (rl >= MAX_CNT) begin
                        b_sh_v = 1'b1;
                        b_sh_h = rbpe_pkg::run_header(8'(rl));
                        b_sh_d = rv;
                        rl     = '0;
                        m      = rbpe_pkg::CM_IDLE;
                    end
                end else begin
                    if (lit_cnt_reg < MAX_CNT) begin
                        mem_we = 1'b1;
                        cnt    = lit_cnt_reg + CW'(1);
                        l2     = last1_reg;
                        l1     = s_tdata;
                    end
                    if (cnt >= MAX_CNT) begin
                        job_lit = 1'b1;
                        job_len = cnt;
                        cnt     = '0;
                        m       = rbpe_pkg::CM_IDLE;
                    end
                end
            end
            rbpe_pkg::CM_RUN: begin
                if (s_tdata == run_val_reg && run_len_reg < MAX_CNT) begin
                    rl = run_len_reg + CW'(1);
                    if (rl >= MAX_CNT) begin
                        b_sh_v = 1'b1;
                        b_sh_h = rbpe_pkg::run_header(8'(rl));
                        b_sh_d = rv;
                        rl     = '0;
                        m      = rbpe_pkg::CM_IDLE;
                    end
                end else begin
                    b_sh_v    = (run_len_reg != '0);
                    b_sh_h    = rbpe_pkg::run_header(8'(run_len_reg));
                    b_sh_d    = run_val_reg;
                    rl        = '0;
                    held      = s_tdata;
                    mem_we    = 1'b1;
                    mem_waddr = AW'(0);
                    m         = rbpe_pkg::CM_HELD;
                end
            end
            default: begin
                m = rbpe_pkg::CM_IDLE;
            end
        endcase

        // flush at the tile end
        if (s_tlast) begin
            case (m)
                rbpe_pkg::CM_HELD: begin
                    e_sh_v = 1'b1;
                    e_sh_h = '0;
                    e_sh_d = held;
                end
                rbpe_pkg::CM_LIT: begin
                    job_lit = (cnt != '0);
                    job_len = cnt;
                    cnt     = '0;
                end
                rbpe_pkg::CM_RUN: begin
                    e_sh_v = (rl != '0);
                    e_sh_h = rbpe_pkg::run_header(8'(rl));
                    e_sh_d = rv;
                    rl     = '0;
                end
                default: begin
                end
            endcase
            m = rbpe_pkg::CM_IDLE;
        end

        job_sh_cnt = {1'b0, b_sh_v} + {1'b0, e_sh_v};
        job_hdr[0] = b_sh_v ? b_sh_h : e_sh_h;
        job_val[0] = b_sh_v ? b_sh_d : e_sh_d;
        job_hdr[1] = e_sh_h;
        job_val[1] = e_sh_d;

        if (acc) begin
            mode_next    = m;
            lit_cnt_next = cnt;
            run_len_next = rl;
            run_val_next = rv;
            held_next    = held;
            last1_next   = l1;
            last2_next   = l2;
        end else begin
            mem_we       = 1'b0;
            mode_next    = mode_reg;
            lit_cnt_next = lit_cnt_reg;
            run_len_next = run_len_reg;
            run_val_next = run_val_reg;
            held_next    = held_reg;
            last1_next   = last1_reg;
            last2_next   = last2_reg;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    assign lit_last = ((idx_reg + CW'(1)) == lit_len_reg);

    always_comb begin : proc_es_next
        es_next = es_reg;
        case (es_reg)
            rbpe_pkg::ES_READY: begin
                if (acc) begin
                    if (job_lit) begin
                        es_next = rbpe_pkg::ES_LHDR;
                    end else if (job_sh_cnt != 2'd0) begin
                        es_next = rbpe_pkg::ES_SHDR;
                    end
                end
            end
            rbpe_pkg::ES_LHDR: begin
                if (push_done) begin
                    es_next = rbpe_pkg::ES_LDATA;
                end
            end
            rbpe_pkg::ES_LDATA: begin
                if (push_done && lit_last) begin
                    es_next = (sh_cnt_reg != 2'd0) ? rbpe_pkg::ES_SHDR : rbpe_pkg::ES_READY;
                end
            end
            rbpe_pkg::ES_SHDR: begin
                if (push_done) begin
                    es_next = rbpe_pkg::ES_SVAL;
                end
            end
            rbpe_pkg::ES_SVAL: begin
                if (push_done) begin
                    es_next = (sh_cnt_reg == 2'd1) ? rbpe_pkg::ES_READY : rbpe_pkg::ES_SHDR;
                end
            end
            default: begin
                es_next = rbpe_pkg::ES_READY;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: byte offered to the assembler
    // ------------------------------------------------------------------
    always_comb begin : proc_es_out
        push_valid = 1'b0;
        push_byte  = '0;
        push_pend  = 1'b0;
        push_jend  = 1'b0;
        case (es_reg)
            rbpe_pkg::ES_LHDR: begin
                push_valid = 1'b1;
                push_byte  = rbpe_pkg::lit_header(8'(lit_len_reg));
            end
            rbpe_pkg::ES_LDATA: begin
                push_valid = 1'b1;
                push_byte  = rd_data_reg;
                push_pend  = lit_last;
                push_jend  = lit_last && (sh_cnt_reg == 2'd0);
            end
            rbpe_pkg::ES_SHDR: begin
                push_valid = 1'b1;
                push_byte  = sh_hdr_reg[0];
            end
            rbpe_pkg::ES_SVAL: begin
                push_valid = 1'b1;
                push_byte  = sh_val_reg[0];
                push_pend  = 1'b1;
                push_jend  = (sh_cnt_reg == 2'd1);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // pending packet bookkeeping
    // ------------------------------------------------------------------
    always_comb begin : proc_pending
        lit_len_next   = lit_len_reg;
        idx_next       = idx_reg;
        sh_cnt_next    = sh_cnt_reg;
        sh_hdr_next[0] = sh_hdr_reg[0];
        sh_hdr_next[1] = sh_hdr_reg[1];
        sh_val_next[0] = sh_val_reg[0];
        sh_val_next[1] = sh_val_reg[1];
        if (acc) begin
            lit_len_next   = job_len;
            idx_next       = '0;
            sh_cnt_next    = job_sh_cnt;
            sh_hdr_next[0] = job_hdr[0];
            sh_hdr_next[1] = job_hdr[1];
            sh_val_next[0] = job_val[0];
            sh_val_next[1] = job_val[1];
        end else if (push_done && es_reg == rbpe_pkg::ES_LDATA) begin
            idx_next = idx_reg + CW'(1);
        end else if (push_done && es_reg == rbpe_pkg::ES_SVAL) begin
            // advance to the second short packet
            sh_cnt_next    = sh_cnt_reg - 2'd1;
            sh_hdr_next[0] = sh_hdr_reg[1];
            sh_val_next[0] = sh_val_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // word assembler and output register
    // ------------------------------------------------------------------
    assign complete  = push_pend || (asm_fill_reg == rbpe_pkg::LANE_LAST);
    assign out_free  = !m_valid_reg || m_tready;
    assign push_done = push_valid && (!complete || out_free);
    assign word_w    = asm_word_reg | (64'(push_byte) << {asm_fill_reg, 3'b000});

    always_comb begin : proc_assemble
        asm_word_next = asm_word_reg;
        asm_fill_next = asm_fill_reg;
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;
        m_count_next  = m_count_reg;
        m_pdone_next  = m_pdone_reg;
        m_last_next   = m_last_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (push_done) begin
            if (complete) begin
                asm_word_next = '0;
                asm_fill_next = '0;
                m_valid_next  = 1'b1;
                m_word_next   = word_w;
                m_count_next  = {1'b0, asm_fill_reg} + 4'd1;
                m_pdone_next  = push_pend;
                m_last_next   = push_jend;
            end else begin
                asm_word_next = word_w;
                asm_fill_next = asm_fill_reg + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= rbpe_pkg::CM_IDLE;
            lit_cnt_reg  <= '0;
            run_len_reg  <= '0;
            run_val_reg  <= '0;
            held_reg     <= '0;
            es_reg       <= rbpe_pkg::ES_READY;
            sh_cnt_reg   <= '0;
            asm_word_reg <= '0;
            asm_fill_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            lit_cnt_reg  <= lit_cnt_next;
            run_len_reg  <= run_len_next;
            run_val_reg  <= run_val_next;
            held_reg     <= held_next;
            es_reg       <= es_next;
            sh_cnt_reg   <= sh_cnt_next;
            asm_word_reg <= asm_word_next;
            asm_fill_reg <= asm_fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last1_reg     <= last1_next;
        last2_reg     <= last2_next;
        lit_len_reg   <= lit_len_next;
        idx_reg       <= idx_next;
        sh_hdr_reg[0] <= sh_hdr_next[0];
        sh_hdr_reg[1] <= sh_hdr_next[1];
        sh_val_reg[0] <= sh_val_next[0];
        sh_val_reg[1] <= sh_val_next[1];
        m_word_reg    <= m_word_next;
        m_count_reg   <= m_count_next;
        m_pdone_reg   <= m_pdone_next;
        m_last_reg    <= m_last_next;
    end

    // literal store: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lit_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= lit_mem[idx_next[AW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_pdone_reg;
    assign m_tdata  = {3'b000, m_last_reg, m_count_reg, m_word_reg};

`ifndef SYNTHESIS
    // no partial word may be left in the assembler while taking a new byte
    a_asm_empty_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (asm_fill_reg == 3'd0))
        else $error("partial word left in assembler while ready");

    // the last word of an item always closes a packet
    a_last_closes_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[68]) |-> m_tlast)
        else $error("last word of item does not end a packet");

    // an open literal holds at least two bytes and is below the packet limit
    a_lit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == rbpe_pkg::CM_LIT) |-> (lit_cnt_reg >= CW'(2) && lit_cnt_reg < MAX_CNT))
        else $error("open literal count out of range");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-run packet encoder.
// Feeds tiles of bytes with random gaps and back-pressure, predicts every
// packet word in a behavioural copy of the encoder and checks each output
// word field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int PKT_MAX      = 128;
    localparam int RANDOM_ITEMS = 188;
    localparam int HOLD_FROM    = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 150;

    localparam logic [7:0] RUN_BIT  = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7f;

    // tile shapes and segment kinds for the random part
    localparam int SHAPE_MIXED    = 0;
    localparam int SHAPE_LONG_LIT = 1;
    localparam int SHAPE_LONG_RUN = 2;
    localparam int SEG_RUN        = 0;
    localparam int SEG_LIT        = 1;
    localparam int SEG_NOISE      = 2;

    typedef struct {
        logic [7:0] data;
        logic       tend;
        logic       pause;
    } tile_byte_t;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        pkt_done;
        logic        last_word;
    } enc_word_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    tile_byte_t  tile_q[$];
    enc_word_t   packet_words[$];
    enc_word_t   step_words[$];

    int          items_sent   = 0;
    int          phase_len    = 1;
    int          errors       = 0;
    int          pause_cycles = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        drained      = 1'b1;

    // behavioural encoder state
    logic [7:0]  lit_buf [PKT_MAX];
    logic [7:0]  pkt [PKT_MAX + 2];
    int          lit_len;
    int          run_len;
    logic [7:0]  run_byte;
    logic [7:0]  held;
    rbpe_pkg::coder_mode_t mode;

    rle_byte_packet_encoder #(
        .MAX_PACKET(PKT_MAX)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Encoder prediction
    // ------------------------------------------------------------------
    task automatic clear_coder();
        lit_len  = 0;
        run_len  = 0;
        run_byte = '0;
        held     = '0;
        mode     = rbpe_pkg::CM_IDLE;
    endtask

    // split pkt[0..len-1] into 8-byte words, first byte lowest
    task automatic emit_packet(input int len);
        int        pos;
        int        take;
        int        i;
        enc_word_t w;
        pos = 0;
        while (pos < len) begin
            take = (len - pos > 8) ? 8 : len - pos;
            w.bytes = '0;
            for (i = 0; i < take; i++)
                w.bytes[8*i +: 8] = pkt[pos + i];
            pos += take;
            w.count     = take[3:0];
            w.pkt_done  = (pos >= len);
            w.last_word = 1'b0;
            step_words.push_back(w);
        end
    endtask

    task automatic emit_literal(input int count);
        int i;
        int hdr;
        if (count > 0) begin
            hdr = count - 1;
            pkt[0] = hdr[7:0] & LEN_MASK;
            for (i = 0; i < count; i++)
                pkt[i + 1] = lit_buf[i];
            emit_packet(count + 1);
        end
    endtask

    task automatic emit_run();
        int hdr;
        if (run_len > 0) begin
            hdr = run_len - 1;
            pkt[0] = RUN_BIT | (hdr[7:0] & LEN_MASK);
            pkt[1] = run_byte;
            emit_packet(2);
        end
    endtask

    task automatic close_full();
        if (mode == rbpe_pkg::CM_RUN && run_len >= PKT_MAX) begin
            emit_run();
            run_len = 0;
            mode = rbpe_pkg::CM_IDLE;
        end else if (mode == rbpe_pkg::CM_LIT && lit_len >= PKT_MAX) begin
            emit_literal(lit_len);
            lit_len = 0;
            mode = rbpe_pkg::CM_IDLE;
        end
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic tend);
        int        i;
        enc_word_t w;
        step_words.delete();
        case (mode)
            rbpe_pkg::CM_IDLE: begin
                held = b;
                mode = rbpe_pkg::CM_HELD;
            end
            rbpe_pkg::CM_HELD: begin
                if (b == held) begin
                    run_byte = b;
                    run_len  = 2;
                    mode     = rbpe_pkg::CM_RUN;
                end else begin
                    lit_buf[0] = held;
                    lit_buf[1] = b;
                    lit_len    = 2;
                    mode       = rbpe_pkg::CM_LIT;
                end
                close_full();
            end
            rbpe_pkg::CM_LIT: begin
                // a third equal byte splits off the last two into a run
                if (lit_len >= 3 && lit_buf[lit_len - 1] == b && lit_buf[lit_len - 2] == b) begin
                    emit_literal(lit_len - 2);
                    lit_len  = 0;
                    run_byte = b;
                    run_len  = 3;
                    mode     = rbpe_pkg::CM_RUN;
                end else if (lit_len < PKT_MAX) begin
                    lit_buf[lit_len] = b;
                    lit_len++;
                end
                close_full();
            end
            default: begin
                if (b == run_byte && run_len < PKT_MAX) begin
                    run_len++;
                    close_full();
                end else begin
                    emit_run();
                    run_len = 0;
                    held    = b;
                    mode    = rbpe_pkg::CM_HELD;
                end
            end
        endcase
        if (tend) begin
            case (mode)
                rbpe_pkg::CM_HELD: begin
                    pkt[0] = '0;
                    pkt[1] = held;
                    emit_packet(2);
                end
                rbpe_pkg::CM_LIT: begin
                    emit_literal(lit_len);
                    lit_len = 0;
                end
                rbpe_pkg::CM_RUN: begin
                    emit_run();
                    run_len = 0;
                end
                default: ;
            endcase
            mode = rbpe_pkg::CM_IDLE;
        end
        for (i = 0; i < step_words.size(); i++) begin
            w = step_words[i];
            w.last_word = (i == step_words.size() - 1);
            packet_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic tend, input logic pause);
        tile_byte_t t;
        t.data  = b;
        t.tend  = tend;
        t.pause = pause;
        tile_q.push_back(t);
    endtask

    task automatic gen_tile(input int shape, input logic force_pause);
        logic [7:0] seg[$];
        logic [7:0] b;
        logic [7:0] prev;
        logic       pause;
        int         nseg;
        int         kind;
        int         len;
        int         s;
        int         i;
        nseg = (shape == SHAPE_MIXED) ? $urandom_range(1, 5) : 1;
        prev = 8'($urandom);
        for (s = 0; s < nseg; s++) begin
            if (shape == SHAPE_LONG_LIT)
                kind = SEG_LIT;
            else if (shape == SHAPE_LONG_RUN)
                kind = SEG_RUN;
            else
                kind = $urandom_range(SEG_RUN, SEG_NOISE);
            case (kind)
                SEG_RUN: begin
                    len = (shape == SHAPE_LONG_RUN) ? $urandom_range(128, 131)
                                                    : $urandom_range(1, 9);
                    b = 8'($urandom);
                    for (i = 0; i < len; i++)
                        seg.push_back(b);
                    prev = b;
                end
                SEG_LIT: begin
                    len = (shape == SHAPE_LONG_LIT) ? $urandom_range(128, 131)
                                                    : $urandom_range(1, 12);
                    // keep neighbours distinct so no run can open
                    for (i = 0; i < len; i++) begin
                        b = 8'($urandom);
                        if (b == prev)
                            b = ~b;
                        seg.push_back(b);
                        prev = b;
                    end
                end
                default: begin
                    // narrow alphabet: stray pairs and triples
                    len = $urandom_range(1, 10);
                    for (i = 0; i < len; i++) begin
                        b = 8'($urandom_range(0, 3));
                        if ($urandom_range(0, 3) == 0)
                            b = b ^ 8'hf0;
                        seg.push_back(b);
                        prev = b;
                    end
                end
            endcase
        end
        pause = force_pause || ($urandom_range(0, 7) == 0);
        for (i = 0; i < seg.size(); i++)
            add_byte(seg[i], i == seg.size() - 1, (i == 0) && pause);
    endtask

    function automatic int tx_idle_pct();
        if (items_sent < phase_len)
            return 22;
        else if (items_sent < 2 * phase_len)
            return 54;
        return 0;
    endfunction

    function automatic int rx_stall_pct();
        if (items_sent < phase_len)
            return 54;
        else if (items_sent < 2 * phase_len)
            return 22;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        logic       offer;
        tile_byte_t nxt;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            pause_cycles = 0;
        end else begin
            if (s_tvalid && s_tready)
                items_sent <= items_sent + 1;
            if (!s_tvalid || s_tready) begin
                if (tile_q.size() != 0) begin
                    // hold a paused tile back until every word has come out
                    if (tile_q[0].pause && !(drained && pause_cycles >= 2)) begin
                        pause_cycles++;
                    end else if ($urandom_range(0, 99) >= tx_idle_pct()) begin
                        nxt = tile_q.pop_front();
                        offer = 1'b1;
                        pause_cycles = 0;
                        s_tdata <= nxt.data;
                        s_tlast <= nxt.tend;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && items_sent >= HOLD_FROM && m_tvalid) begin
            // long hold while the sender keeps offering
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct());
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        enc_word_t exp_w;
        if (!aresetn) begin
            clear_coder();
            packet_words.delete();
            drained <= 1'b1;
        end else begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (packet_words.size() == 0) begin
                    $error("unexpected word: tdata %h tlast %b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    exp_w = packet_words.pop_front();
                    if (m_tdata[63:0] !== exp_w.bytes) begin
                        $error("word_bytes: expected %h, got %h", exp_w.bytes, m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[67:64] !== exp_w.count) begin
                        $error("byte_count: expected %0d, got %0d", exp_w.count,
                               m_tdata[67:64]);
                        errors++;
                    end
                    if (m_tdata[68] !== exp_w.last_word) begin
                        $error("last_word: expected %b, got %b", exp_w.last_word, m_tdata[68]);
                        errors++;
                    end
                    if (m_tlast !== exp_w.pkt_done) begin
                        $error("packet_done: expected %b, got %b", exp_w.pkt_done, m_tlast);
                        errors++;
                    end
                end
            end
            drained <= (packet_words.size() == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int directed_len;

        // lone final byte
        add_byte(8'h00, 1'b1, 1'b0);
        // tile ends on an equal pair, then on a differing pair
        add_byte(8'hff, 1'b0, 1'b0);
        add_byte(8'hff, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hff, 1'b1, 1'b0);
        // triple inside a literal, then a lone byte after the run
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h02, 1'b0, 1'b0);
        add_byte(8'h03, 1'b0, 1'b0);
        add_byte(8'h03, 1'b0, 1'b0);
        add_byte(8'h03, 1'b0, 1'b0);
        add_byte(8'h55, 1'b1, 1'b0);
        // run broken by a different byte
        add_byte(8'haa, 1'b0, 1'b0);
        add_byte(8'haa, 1'b0, 1'b0);
        add_byte(8'haa, 1'b0, 1'b0);
        add_byte(8'h5a, 1'b1, 1'b0);
        // literal closed by the tile end
        add_byte(8'h10, 1'b0, 1'b0);
        add_byte(8'h20, 1'b0, 1'b0);
        add_byte(8'h30, 1'b1, 1'b0);
        // run closed by the tile end
        add_byte(8'h77, 1'b0, 1'b0);
        add_byte(8'h77, 1'b0, 1'b0);
        add_byte(8'h77, 1'b0, 1'b0);
        add_byte(8'h77, 1'b1, 1'b0);
        directed_len = tile_q.size();

        // full literal first, then mixed tiles
        gen_tile(SHAPE_LONG_LIT, 1'b1);
        while (tile_q.size() - directed_len < RANDOM_ITEMS)
            gen_tile(SHAPE_MIXED, 1'b0);
        phase_len = tile_q.size() / 3;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (tile_q.size() != 0 || s_tvalid || packet_words.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && packet_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
